// ===== rtl/polyphonic_siren_voice_synth_core_macros.svh =====
// Assertion macros used by the siren synthesizer core.
`ifndef POLYPHONIC_SIREN_VOICE_SYNTH_CORE_MACROS_SVH
`define POLYPHONIC_SIREN_VOICE_SYNTH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSVS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PSVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/psvs_pkg.sv =====
// Shared constants, types and helpers of the siren synthesizer.
package psvs_pkg;

    localparam int unsigned NUM_VOICES_DEF = 4;

    localparam int REQ_W   = 2;
    localparam int DUR_W   = 13;
    localparam int LEVEL_W = 8;
    localparam int ACT_W   = 3;
    localparam int SAMP_W  = 18;
    localparam int PITCH_W = 32;
    localparam int PHASE_W = 32;
    localparam int FREQ_W  = 33;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIG   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_KILL   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [PITCH_W-1:0] START_PITCH  = 32'd4194304000;
    localparam logic [PHASE_W-1:0] LFO_STEP     = 32'd1889786;
    localparam logic [15:0]        DECAY_MUL    = 16'd65503;
    localparam logic [16:0]        VCO_MUL      = 17'd94489;
    localparam logic [FREQ_W-1:0]  WOBBLE_Q     = 33'd629145600;
    localparam logic [FREQ_W-1:0]  MIN_PITCH    = 33'd41943040;
    localparam logic [FREQ_W-1:0]  WOB_PLUS_MIN = 33'd671088640;

    localparam logic [15:0]       RATE_HZ     = 16'd45454;
    localparam logic [20:0]       MS_RECIP    = 21'd1073741;
    localparam logic [9:0]        MS_DIV      = 10'd1000;
    localparam logic [SAMP_W-1:0] SAMPLES_MAX = 18'h3FFFF;
    localparam int unsigned       LEVEL_HIGH  = 255;

    typedef struct packed {
        logic [SAMP_W-1:0]  samples;
        logic [PITCH_W-1:0] pitch;
        logic [PHASE_W-1:0] osc;
        logic [PHASE_W-1:0] wob;
    } voice_rec_t;

    typedef struct packed {
        logic done;
        logic high;
        logic expire;
    } upd_res_t;

    typedef struct packed {
        logic              done;
        logic [SAMP_W-1:0] samples;
    } dur_res_t;

    function automatic logic [ACT_W-1:0] sat_count(input logic [31:0] n);
        logic [ACT_W-1:0] r;
        r = (n > 32'd7) ? 3'd7 : n[ACT_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/psvs_ifs.sv =====
// Valid/ready channel interfaces for request and result items.
interface psvs_req_if;
    logic                          valid;
    logic                          ready;
    logic [psvs_pkg::REQ_W-1:0]    req_type;
    logic [psvs_pkg::DUR_W-1:0]    duration_ms;

    modport source (output valid, output req_type, output duration_ms, input ready);
    modport sink (input valid, input req_type, input duration_ms, output ready);
endinterface

interface psvs_res_if;
    logic                          valid;
    logic                          ready;
    logic [psvs_pkg::LEVEL_W-1:0]  sample_level;
    logic [psvs_pkg::ACT_W-1:0]    active_voices;
    logic                          trigger_taken;

    modport source (output valid, output sample_level, output active_voices,
                    output trigger_taken, input ready);
    modport sink (input valid, input sample_level, input active_voices,
                  input trigger_taken, output ready);
endinterface

// ===== rtl/polyphonic_siren_voice_synth_core.sv =====
// Polyphonic siren synthesizer: up to NUM_VOICES square-wave voices with decaying
// pitch and a square-LFO wobble, mixed into one 8-bit level per sample tick. The
// per-voice state sits in a one-port-write, one-port-read memory and one voice at a
// time goes through a read, decay multiply, pitch multiply and write-back pipeline.
// A tick visits each voice in turn and runs only the active ones through the
// pipeline. A trigger waits for the four-stage millisecond-to-sample converter;
// kill and unused request codes go straight to the result. One item is in work at a
// time; a new request is taken while the previous result still waits in the output
// register.
`include "polyphonic_siren_voice_synth_core_macros.svh"

module polyphonic_siren_voice_synth_core #(
    parameter int unsigned NUM_VOICES = psvs_pkg::NUM_VOICES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    psvs_req_if.sink   req,
    psvs_res_if.source res
);

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_TRIG = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [NUM_VOICES-1:0] voice_on_reg, voice_on_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      tidx_reg, tidx_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [psvs_pkg::ACT_W-1:0] act_reg, act_next;
    logic                  taken_reg, taken_next;
    logic                  tick_reg, tick_next;

    logic                          out_valid_reg;
    logic [psvs_pkg::LEVEL_W-1:0]  out_level_reg;
    logic [psvs_pkg::ACT_W-1:0]    out_act_reg;
    logic                          out_taken_reg;

    logic [psvs_pkg::LEVEL_W-1:0] lvl_tab [NUM_VOICES+1];

    logic              req_acc;
    logic [CNT_W-1:0]  on_cnt;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              last_voice;
    logic              upd_start, trig_wr, conv_start, load_out;

    psvs_pkg::upd_res_t eng_res;
    psvs_pkg::dur_res_t conv_res;

    // Level for each count of voices in the high half of their cycle.
    for (genvar g = 0; g <= NUM_VOICES; g++)
    begin : g_lvl
        localparam int unsigned LVL = (psvs_pkg::LEVEL_HIGH * g) / NUM_VOICES;
        assign lvl_tab[g] = psvs_pkg::LEVEL_W'(LVL);
    end

    psvs_dur_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (conv_start),
        .dur      (req.duration_ms),
        .conv_res (conv_res)
    );

    psvs_voice_engine #(
        .NUM_VOICES (NUM_VOICES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd_start    (upd_start),
        .upd_idx      (idx_reg),
        .trig_wr      (trig_wr),
        .trig_idx     (tidx_reg),
        .trig_samples (conv_res.samples),
        .upd_res      (eng_res)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign last_voice = (idx_reg == IDX_W'(NUM_VOICES - 1));

    always_comb
    begin
        on_cnt = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            on_cnt = on_cnt + CNT_W'(voice_on_reg[i]);
        end
    end

    // Lowest free voice wins.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (!voice_on_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        voice_on_next = voice_on_reg;
        idx_next      = idx_reg;
        tidx_next     = tidx_reg;
        hi_next       = hi_reg;
        act_next      = act_reg;
        taken_next    = taken_reg;
        tick_next     = tick_reg;
        upd_start     = 1'b0;
        trig_wr       = 1'b0;
        conv_start    = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    tick_next  = 1'b0;
                    taken_next = 1'b0;
                    hi_next    = '0;
                    idx_next   = '0;
                    act_next   = psvs_pkg::sat_count(32'(on_cnt));
                    unique case (req.req_type)
                        psvs_pkg::REQ_TICK:
                        begin
                            tick_next  = 1'b1;
                            state_next = ST_TICK;
                        end
                        psvs_pkg::REQ_TRIG:
                        begin
                            if (free_found)
                            begin
                                conv_start = 1'b1;
                                tidx_next  = free_idx;
                                state_next = ST_TRIG;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        psvs_pkg::REQ_KILL:
                        begin
                            voice_on_next = '0;
                            act_next      = '0;
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (voice_on_reg[idx_reg])
                begin
                    upd_start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else if (last_voice)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (eng_res.done)
                begin
                    hi_next = hi_reg + CNT_W'(eng_res.high);
                    if (eng_res.expire)
                    begin
                        voice_on_next[idx_reg] = 1'b0;
                    end
                    if (last_voice)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_TICK;
                    end
                end
            end
            ST_TRIG:
            begin
                if (conv_res.done)
                begin
                    trig_wr                 = 1'b1;
                    voice_on_next[tidx_reg] = 1'b1;
                    taken_next              = 1'b1;
                    act_next                = psvs_pkg::sat_count(32'(on_cnt) + 32'd1);
                    state_next              = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            voice_on_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            voice_on_reg <= voice_on_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        tidx_reg  <= tidx_next;
        hi_reg    <= hi_next;
        act_reg   <= act_next;
        taken_reg <= taken_next;
        tick_reg  <= tick_next;
        if (load_out)
        begin
            out_level_reg <= tick_reg ? lvl_tab[hi_reg] : '0;
            out_act_reg   <= act_reg;
            out_taken_reg <= taken_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.sample_level  = out_level_reg;
    assign res.active_voices = out_act_reg;
    assign res.trigger_taken = out_taken_reg;

    `PSVS_ASSERT_IMP(a_upd_in_wait, eng_res.done, state_reg == ST_WAIT)
    `PSVS_ASSERT_IMP(a_conv_in_trig, conv_res.done, state_reg == ST_TRIG)
    `PSVS_ASSERT_IMP(a_trig_silent, res.valid && res.trigger_taken, res.sample_level == '0)
    `PSVS_ASSERT_NEXT(a_kill_clears, req_acc && req.req_type == psvs_pkg::REQ_KILL, voice_on_reg == '0)

endmodule

// ===== rtl/psvs_dur_conv.sv =====
// Converts a duration in milliseconds to a saturated sample count over four stages.
module psvs_dur_conv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psvs_pkg::DUR_W-1:0]  dur,
    output psvs_pkg::dur_res_t          conv_res
);

    logic        a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic [28:0] a_p_reg, b_p_reg, c_p_reg;
    logic [49:0] b_m_reg;
    logic [19:0] c_q_reg;
    logic [psvs_pkg::SAMP_W-1:0] d_samp_reg;

    logic [29:0] rem;
    logic [19:0] quot;
    logic [psvs_pkg::SAMP_W-1:0] samp_next;

    // The reciprocal estimate is never high and at most one low; one compare fixes it.
    always_comb
    begin
        rem  = 30'(c_p_reg) - 30'(c_q_reg * 30'(psvs_pkg::MS_DIV));
        quot = (rem >= 30'(psvs_pkg::MS_DIV)) ? c_q_reg + 20'd1 : c_q_reg;
        samp_next = (quot > 20'(psvs_pkg::SAMPLES_MAX)) ? psvs_pkg::SAMPLES_MAX
                                                        : quot[psvs_pkg::SAMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg    <= 29'(dur) * 29'(psvs_pkg::RATE_HZ);
        b_p_reg    <= a_p_reg;
        b_m_reg    <= 50'(a_p_reg) * 50'(psvs_pkg::MS_RECIP);
        c_p_reg    <= b_p_reg;
        c_q_reg    <= b_m_reg[49:30];
        d_samp_reg <= samp_next;
    end

    assign conv_res.done    = d_v_reg;
    assign conv_res.samples = d_samp_reg;

endmodule

// ===== rtl/psvs_voice_engine.sv =====
// Voice state memory with the read-modify-write pipeline that advances one voice.
module psvs_voice_engine #(
    parameter  int unsigned NUM_VOICES = psvs_pkg::NUM_VOICES_DEF,
    localparam int          IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         upd_start,
    input  logic [IDX_W-1:0]             upd_idx,
    input  logic                         trig_wr,
    input  logic [IDX_W-1:0]             trig_idx,
    input  logic [psvs_pkg::SAMP_W-1:0]  trig_samples,
    output psvs_pkg::upd_res_t           upd_res
);

    psvs_pkg::voice_rec_t mem [NUM_VOICES];
    psvs_pkg::voice_rec_t rd_reg;

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg;

    logic [47:0]                  s2_decay_reg;
    logic [psvs_pkg::SAMP_W-1:0]  s2_samp_reg, s3_samp_reg;
    logic [psvs_pkg::PHASE_W-1:0] s2_osc_reg, s3_osc_reg;
    logic [psvs_pkg::PHASE_W-1:0] s2_wob_reg, s3_wob_reg;
    logic [psvs_pkg::PITCH_W-1:0] s3_pitch_reg;
    logic [49:0]                  s3_vco_reg;

    logic [psvs_pkg::PITCH_W-1:0] pitch_new;
    logic [psvs_pkg::FREQ_W-1:0]  freq;
    logic [psvs_pkg::PHASE_W-1:0] osc_new;
    logic [psvs_pkg::SAMP_W-1:0]  samp_new;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_idx;
    psvs_pkg::voice_rec_t         wr_data;

    // The wobble is added, or subtracted and clamped at the minimum pitch.
    always_comb
    begin
        pitch_new = s2_decay_reg[47:16];
        if (!s2_wob_reg[psvs_pkg::PHASE_W-1])
        begin
            freq = 33'(pitch_new) + psvs_pkg::WOBBLE_Q;
        end
        else if (33'(pitch_new) < psvs_pkg::WOB_PLUS_MIN)
        begin
            freq = psvs_pkg::MIN_PITCH;
        end
        else
        begin
            freq = 33'(pitch_new) - psvs_pkg::WOBBLE_Q;
        end
    end

    always_comb
    begin
        osc_new  = s3_osc_reg + 32'(s3_vco_reg[49:21]);
        samp_new = (s3_samp_reg <= 18'd1) ? '0 : s3_samp_reg - 18'd1;
        wr_en    = trig_wr || s3_v_reg;
        if (trig_wr)
        begin
            wr_idx          = trig_idx;
            wr_data.samples = trig_samples;
            wr_data.pitch   = psvs_pkg::START_PITCH;
            wr_data.osc     = '0;
            wr_data.wob     = '0;
        end
        else
        begin
            wr_idx          = s3_idx_reg;
            wr_data.samples = samp_new;
            wr_data.pitch   = s3_pitch_reg;
            wr_data.osc     = osc_new;
            wr_data.wob     = s3_wob_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (upd_start)
        begin
            rd_reg <= mem[upd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= upd_start;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= upd_idx;
        s2_idx_reg   <= s1_idx_reg;
        s2_decay_reg <= 48'(rd_reg.pitch) * 48'(psvs_pkg::DECAY_MUL);
        s2_samp_reg  <= rd_reg.samples;
        s2_osc_reg   <= rd_reg.osc;
        s2_wob_reg   <= rd_reg.wob + psvs_pkg::LFO_STEP;
        s3_idx_reg   <= s2_idx_reg;
        s3_samp_reg  <= s2_samp_reg;
        s3_osc_reg   <= s2_osc_reg;
        s3_wob_reg   <= s2_wob_reg;
        s3_pitch_reg <= pitch_new;
        s3_vco_reg   <= 50'(freq) * 50'(psvs_pkg::VCO_MUL);
    end

    assign upd_res.done   = s3_v_reg;
    assign upd_res.high   = ~osc_new[psvs_pkg::PHASE_W-1];
    assign upd_res.expire = (s3_samp_reg <= 18'd1);

endmodule
